// File: rtl/ptd_pkg.sv
// ----------------------------------------------------------------------------
// Trial-division prime counter package
// Sequencer states, divider status and fixed constants shared by the block.
// ----------------------------------------------------------------------------
package ptd_pkg;

   // first trial divisor
   localparam int unsigned FIRST_DIVISOR = 2;

   // fixed stream widths
   localparam int unsigned REQ_DATA_BITS = 16;
   localparam int unsigned RSP_DATA_BITS = 24;
   localparam int unsigned OUT_COUNT_BITS = 16;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIVIDE,
      ST_RESULT
   } state_type;

   // divider status back to the sequencer
   typedef struct packed {
      logic done;   // one-cycle pulse, remainder is final
      logic zero;   // remainder is zero
   } div_status_type;

endpackage

// File: rtl/prime_count_trial_division_top.sv
// ----------------------------------------------------------------------------
// Trial-division prime counter
// Tests each word for primality by trial division and keeps a saturating
// count of primes per set, cleared after the last word of a set.
// ----------------------------------------------------------------------------
//
//   channel | dir | tdata                                    | tlast
//   --------+-----+------------------------------------------+----------
//   req_    | in  | [15:0] value                             | last
//   rsp_    | out | [0] is_prime, [16:1] prime_count, 0 pad  | set_done
//
// Each trial divisor takes one pass of the bit-serial remainder unit, for
// up to about sqrt(value) divisors; values below 4 finish without any
// division. Reset is synchronous and clears the count and handshakes.
// req_tready is high only while idle; a finished word waits in the output
// register and a stalled rsp_ side holds the sequencer in its result state.
//
module prime_count_trial_division_top #(
   parameter int VALUE_BITS = 16,
   parameter int COUNT_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,    // [15:0] value
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,    // [0] is_prime, [16:1] prime_count
   output logic        rsp_tlast
);
   import ptd_pkg::*;

   localparam int SQ_W = VALUE_BITS + 1;
   localparam logic [VALUE_BITS-1:0] D_FIRST = VALUE_BITS'(FIRST_DIVISOR);
   localparam logic [SQ_W-1:0] SQ_FIRST = SQ_W'(FIRST_DIVISOR * FIRST_DIVISOR);

   state_type             state_ff, state_in;
   logic [VALUE_BITS-1:0] v_ff, v_in;
   logic [VALUE_BITS-1:0] d_ff, d_in;
   logic [SQ_W-1:0]       sq_ff, sq_in;
   logic                  last_ff, last_in;
   logic                  prime_ff, prime_in;
   logic [COUNT_BITS-1:0] count_ff, count_next;
   logic                  rsp_valid_ff;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff;
   logic                  rsp_last_ff;
   logic                  div_start;
   logic                  load_rsp;
   logic                  req_ready;
   div_status_type        div_stat;

   // shared remainder unit
   ptd_divider #(
      .VALUE_BITS (VALUE_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (v_ff),
      .divisor  (d_ff),
      .status   (div_stat)
   );

   // sequencer: next state and controls
   always_comb begin
      state_in  = state_ff;
      v_in      = v_ff;
      d_in      = d_ff;
      sq_in     = sq_ff;
      last_in   = last_ff;
      prime_in  = prime_ff;
      div_start = 1'b0;
      load_rsp  = 1'b0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_tvalid) begin
               v_in     = VALUE_BITS'(req_tdata);
               last_in  = req_tlast;
               d_in     = D_FIRST;
               sq_in    = SQ_FIRST;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (v_ff < D_FIRST) begin
               // zero and one are not prime
               prime_in = 1'b0;
               state_in = ST_RESULT;
            end else if (sq_ff > {1'b0, v_ff}) begin
               // divisor passed the square root: no factor found
               prime_in = 1'b1;
               state_in = ST_RESULT;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_stat.done) begin
               if (div_stat.zero) begin
                  prime_in = 1'b0;
                  state_in = ST_RESULT;
               end else begin
                  // (d+1)^2 = d^2 + 2d + 1
                  d_in     = d_ff + 1'b1;
                  sq_in    = sq_ff + {d_ff, 1'b1};
                  state_in = ST_CHECK;
               end
            end
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // saturating count including this word
   always_comb begin
      count_next = count_ff;
      if (prime_ff && (count_ff != '1)) begin
         count_next = count_ff + 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         state_ff <= state_in;
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
            count_ff     <= last_ff ? '0 : count_next;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      v_ff     <= v_in;
      d_ff     <= d_in;
      sq_ff    <= sq_in;
      last_ff  <= last_in;
      prime_ff <= prime_in;
      if (load_rsp) begin
         rsp_data_ff <= {{(RSP_DATA_BITS - OUT_COUNT_BITS - 1){1'b0}},
                         OUT_COUNT_BITS'(count_next), prime_ff};
         rsp_last_ff <= last_ff;
      end
   end

   assign req_tready = req_ready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // a prime result never comes from a value below two
   a_prime_min: assert property (@(posedge clock) disable iff (reset)
      (load_rsp && prime_ff) |-> (v_ff >= D_FIRST))
      else $error("prime reported for value below two");

   // a division only runs while divisor squared is within the value
   a_div_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> (sq_ff <= {1'b0, v_ff}))
      else $error("trial divisor beyond square root");

   // inside a set the count never falls
   a_count_mono: assert property (@(posedge clock) disable iff (reset)
      (load_rsp && !last_ff) |=> (count_ff >= $past(count_ff)))
      else $error("prime count decreased inside a set");

endmodule

// File: rtl/ptd_divider.sv
// ----------------------------------------------------------------------------
// Remainder unit
// Restoring shift-subtract remainder, one dividend bit per cycle. Operands
// must hold stable from start until done.
// ----------------------------------------------------------------------------
module ptd_divider #(
   parameter int VALUE_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [VALUE_BITS-1:0]      dividend,
   input  logic [VALUE_BITS-1:0]      divisor,
   output ptd_pkg::div_status_type    status
);
   import ptd_pkg::*;

   localparam int CNT_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [VALUE_BITS-1:0] rem_ff, rem_in;
   logic [VALUE_BITS:0]   trial;

   // start load or one shift-subtract step
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      trial   = {rem_ff, dividend[cnt_ff]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(VALUE_BITS - 1);
         rem_in  = '0;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in = VALUE_BITS'(trial - {1'b0, divisor});
         end else begin
            rem_in = trial[VALUE_BITS-1:0];
         end
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
   end

   assign status.done = done_ff;
   assign status.zero = (rem_ff == '0);

endmodule

// File: tb/prime_count_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Prime counter stream checker
// Watches both stream channels, predicts the prime flag and the saturating
// per-set prime count of every accepted request word, and compares each
// response word against the oldest prediction.
// ----------------------------------------------------------------------------
module prime_count_checker #(
   parameter int VALUE_BITS = 16,
   parameter int COUNT_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [ptd_pkg::REQ_DATA_BITS-1:0] req_tdata,   // [15:0] value
   input  logic                             req_tlast,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [ptd_pkg::RSP_DATA_BITS-1:0] rsp_tdata,   // [0] is_prime, [16:1] count
   input  logic                             rsp_tlast,
   output int                               failures,
   output int                               outstanding
);
   import ptd_pkg::*;

   typedef struct packed {
      logic                      is_prime;
      logic [OUT_COUNT_BITS-1:0] prime_count;
      logic                      set_done;
   } prime_result_type;

   prime_result_type        pending_results[$];
   logic [COUNT_BITS-1:0]   set_primes;
   int                      rsp_words;
   int                      shown;

   initial begin
      failures = 0;
      outstanding = 0;
      rsp_words = 0;
      shown = 0;
   end

   // trial division: divisors from the first one while divisor squared fits
   function automatic logic prime_by_trial(input logic [VALUE_BITS-1:0] value);
      longint unsigned v;
      longint unsigned d;
      v = value;
      if (v < FIRST_DIVISOR) return 1'b0;
      for (d = FIRST_DIVISOR; d * d <= v; d++) begin
         if (v % d == 0) return 1'b0;
      end
      return 1'b1;
   endfunction

   // predict on request words, compare on response words
   always @(posedge clock) begin
      prime_result_type      want;
      logic                  prime;
      logic [COUNT_BITS-1:0] next_count;
      int                    bad;
      bad = 0;
      if (reset) begin
         set_primes <= '0;
         pending_results.delete();
         outstanding <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               bad = 1;
               if (shown < 10)
                  $display("%0t: response word %0d with no prediction: data=%h last=%b",
                           $realtime, rsp_words, rsp_tdata, rsp_tlast);
            end else begin
               want = pending_results.pop_front();
               if (rsp_tdata[0] !== want.is_prime ||
                   rsp_tdata[OUT_COUNT_BITS:1] !== want.prime_count ||
                   rsp_tdata[RSP_DATA_BITS-1:OUT_COUNT_BITS+1] !== '0 ||
                   rsp_tlast !== want.set_done) begin
                  bad = 1;
                  if (shown < 10) begin
                     $display("%0t: response word %0d mismatch", $realtime, rsp_words);
                     $display("   expected prime=%b count=%0d done=%b pad=0",
                              want.is_prime, want.prime_count, want.set_done);
                     $display("   got      prime=%b count=%0d done=%b pad=%h",
                              rsp_tdata[0], rsp_tdata[OUT_COUNT_BITS:1], rsp_tlast,
                              rsp_tdata[RSP_DATA_BITS-1:OUT_COUNT_BITS+1]);
                  end
               end
            end
            rsp_words <= rsp_words + 1;
         end
         if (req_tvalid && req_tready) begin
            prime = prime_by_trial(req_tdata[VALUE_BITS-1:0]);
            // count saturates at all ones, clears after the last word of a set
            next_count = (prime && set_primes != '1) ? set_primes + 1'b1 : set_primes;
            want.is_prime = prime;
            want.prime_count = OUT_COUNT_BITS'(next_count);
            want.set_done = req_tlast;
            pending_results.push_back(want);
            set_primes <= req_tlast ? '0 : next_count;
         end
         outstanding <= pending_results.size();
      end
      if (bad != 0) begin
         failures <= failures + 1;
         shown <= shown + 1;
      end
   end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Prime counter testbench
// Drives directed and random sets of values into the trial-division prime
// counter with random gaps and back-pressure; the checker predicts and
// compares every response word.
// ----------------------------------------------------------------------------
module tb;
   import ptd_pkg::*;

   localparam int VALUE_BITS = 16;
   localparam int COUNT_BITS = 16;
   localparam int DRAIN_CYCLES = 200;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;   // [15:0] value
   logic                     req_tlast = 1'b0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;        // [0] is_prime, [16:1] prime_count
   logic                     rsp_tlast;

   int failures;
   int outstanding;
   int send_idle_pct = 27;
   int recv_idle_pct = 53;
   int random_sent = 0;

   logic [15:0] small_primes [16] = '{16'd2, 16'd3, 16'd5, 16'd7, 16'd11, 16'd13, 16'd17,
                                      16'd19, 16'd23, 16'd29, 16'd31, 16'd37, 16'd41,
                                      16'd43, 16'd47, 16'd53};

   always #10 clock = ~clock;

   prime_count_trial_division_top #(
      .VALUE_BITS(VALUE_BITS),
      .COUNT_BITS(COUNT_BITS)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

   prime_count_checker #(
      .VALUE_BITS(VALUE_BITS),
      .COUNT_BITS(COUNT_BITS)
   ) u_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .failures   (failures),
      .outstanding(outstanding)
   );

   // response back-pressure
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // one request word, with random idle cycles ahead of it
   task automatic send_word(input logic [15:0] value, input logic last);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= value;
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // mostly small values; a few large ones, squares and dense primes
   function automatic logic [15:0] pick_value(input logic dense);
      int unsigned root;
      if (dense && $urandom_range(0, 4) != 0)
         return small_primes[$urandom_range(0, 15)];
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return 16'($urandom_range(0, 63));
         4, 5:       return 16'($urandom_range(0, 4095));
         6:          return 16'($urandom_range(0, 65535));
         7:          return small_primes[$urandom_range(0, 15)];
         8:          return 16'($urandom_range(65000, 65535));
         default: begin
            root = $urandom_range(2, 255);
            return 16'(root * root);
         end
      endcase
   endfunction

   // whole sets of random length until the word target is reached
   task automatic send_random_sets(input int target);
      int   len;
      int   i;
      logic dense;
      while (random_sent < target) begin
         dense = ($urandom_range(0, 3) == 0);
         len = ($urandom_range(0, 3) == 0) ? $urandom_range(14, 24) : $urandom_range(1, 8);
         for (i = 0; i < len; i++) begin
            send_word(pick_value(dense), i == len - 1);
            random_sent++;
         end
      end
   endtask

   // stimulus and verdict
   initial begin
      int i;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // zero and one, edges of the divisor loop, widest values
      send_word(16'd0, 1'b0);
      send_word(16'd1, 1'b0);
      send_word(16'd2, 1'b0);
      send_word(16'd4, 1'b0);
      send_word(16'd25, 1'b0);
      send_word(16'd65025, 1'b0);
      send_word(16'hffff, 1'b0);
      send_word(16'd65521, 1'b1);
      // set of a single word
      send_word(16'd7, 1'b1);
      // a set made only of primes
      for (i = 0; i < 16; i++) send_word(small_primes[i], i == 15);

      send_random_sets(38);
      send_idle_pct = 53;
      recv_idle_pct = 27;
      send_random_sets(77);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_random_sets(115);
      req_tvalid <= 1'b0;

      // let the checker see the last accepted word before draining
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0 && outstanding == 0)
         $display("prime_count_trial_division_top verification clean");
      else
         $display("prime_count_trial_division_top verification failed");
      $finish;
   end

   // run limit
   initial begin
      #100_000_000;
      $display("prime_count_trial_division_top verification failed");
      $finish;
   end

endmodule

// File: files.f
rtl/ptd_pkg.sv
rtl/ptd_divider.sv
rtl/prime_count_trial_division_top.sv
tb/prime_count_checker.sv
tb/tb.sv
